### design/ptgs_pkg.sv
// shared constants and codes for the probabilistic table gate sampler
// no dependencies; imported by the sampler top level and its port checker
package ptgs_pkg;

	localparam int DEF_MAX_IN_BITS  = 4;
	localparam int DEF_MAX_OUT_BITS = 4;
	localparam int DEF_PROB_BITS    = 16;

	// configuration port geometry
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_BITS  = 1'b0,
		REG_OUT_BITS = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_WRITE  = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

endpackage

### design/probabilistic_table_gate_sampler_unit.sv
// Categorical sampler: a row-wide probability table and a pipelined inverse-CDF draw.
// A write transaction stores one entry and gives no result; a sample transaction gives
// one output pattern. One transaction is accepted per cycle while in_ready is high. A sample
// passes these registered steps from acceptance to a valid result: its row
// is read from the table and registered at the accepting edge, then each
// parallel-prefix adder level over the row (log2 of the column count) registers its sums, and
// the compare and priority pick feed the output register. Stalls on the output back up
// through the stages without loss.
// Table contents are undefined after reset; there is no clearing pass.
// Depends on ptgs_pkg.
module probabilistic_table_gate_sampler_unit #(
	parameter int MAX_IN_BITS  = ptgs_pkg::DEF_MAX_IN_BITS,
	parameter int MAX_OUT_BITS = ptgs_pkg::DEF_MAX_OUT_BITS,
	parameter int PROB_BITS    = ptgs_pkg::DEF_PROB_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ptgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptgs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [MAX_IN_BITS-1:0]          input_pattern,
	input  logic [MAX_OUT_BITS-1:0]         entry_column,
	input  logic [PROB_BITS-1:0]            entry_probability,
	input  logic [PROB_BITS-1:0]            random_fraction,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [MAX_OUT_BITS-1:0]         output_pattern
);
	import ptgs_pkg::*;

	localparam int ROWS  = 1 << MAX_IN_BITS;
	localparam int COLS  = 1 << MAX_OUT_BITS;
	localparam int LV    = MAX_OUT_BITS;
	localparam int SUM_W = PROB_BITS + MAX_OUT_BITS;

	logic [CFG_W-1:0] in_bits_q;
	logic [CFG_W-1:0] out_bits_q;
	logic [CFG_W-1:0] ib_eff;
	logic [CFG_W-1:0] ob_eff;

	logic [PROB_BITS-1:0] mem_q [ROWS][COLS];

	logic [SUM_W-1:0]     pfx_sk [LV+1][COLS];
	logic [PROB_BITS-1:0] rnd_sk [LV+1];
	logic [LV:0]          vld_sk;
	logic [LV+1:0]        en;

	logic [MAX_IN_BITS-1:0]  row_mask;
	logic [MAX_IN_BITS-1:0]  rd_row;
	logic [MAX_OUT_BITS-1:0] col_mask;
	logic [MAX_OUT_BITS-1:0] chosen;
	logic [COLS-1:0]         hit;
	logic                    accept;

	logic                    out_valid_q;
	logic [MAX_OUT_BITS-1:0] out_pat_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bits_q  <= '0;
			out_bits_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IN_BITS:  in_bits_q  <= cfg_data;
				REG_OUT_BITS: out_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ib_eff = (in_bits_q > CFG_W'(MAX_IN_BITS)) ? CFG_W'(MAX_IN_BITS) : in_bits_q;
	assign ob_eff = (out_bits_q > CFG_W'(MAX_OUT_BITS)) ? CFG_W'(MAX_OUT_BITS) : out_bits_q;

	assign row_mask = ~({MAX_IN_BITS{1'b1}} << ib_eff);
	assign rd_row   = input_pattern & row_mask;
	assign col_mask = ~({MAX_OUT_BITS{1'b1}} << ob_eff);

	// handshake: each stage moves when it is empty or the next one moves
	assign en[LV+1] = !out_valid_q || out_ready;
	for (genvar k = 0; k <= LV; k++) begin : g_en
		assign en[k] = !vld_sk[k] || en[k+1];
	end

	assign in_ready = en[0];
	assign accept   = in_valid && in_ready;

	// table: one row per input pattern, one lane per column
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_WRITE) begin
			mem_q[input_pattern][entry_column] <= entry_probability;
		end
	end

	// row read, registered as prefix level zero
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int c = 0; c < COLS; c++) begin
				pfx_sk[0][c] <= SUM_W'(mem_q[rd_row][c]);
			end
			rnd_sk[0] <= random_fraction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[0] <= 1'b0;
		end else if (en[0]) begin
			vld_sk[0] <= in_valid && mode == MODE_SAMPLE;
		end
	end

	// parallel prefix: level k adds the lane 2^k to the left
	for (genvar k = 0; k < LV; k++) begin : g_lvl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else if (en[k+1]) begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				rnd_sk[k+1] <= rnd_sk[k];
			end
		end

		for (genvar c = 0; c < COLS; c++) begin : g_lane
			if (c >= (1 << k)) begin : g_add
				always_ff @(posedge clk) begin
					if (en[k+1]) begin
						pfx_sk[k+1][c] <= pfx_sk[k][c] + pfx_sk[k][c-(1<<k)];
					end
				end
			end else begin : g_pass
				always_ff @(posedge clk) begin
					if (en[k+1]) begin
						pfx_sk[k+1][c] <= pfx_sk[k][c];
					end
				end
			end
		end
	end

	// first column in use whose running sum exceeds the fraction, else the last one
	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			hit[c] = (pfx_sk[LV][c] > SUM_W'(rnd_sk[LV]))
				&& ((MAX_OUT_BITS'(c) & ~col_mask) == '0);
		end
		chosen = col_mask;
		for (int c = COLS - 1; c >= 0; c--) begin
			if (hit[c]) begin
				chosen = MAX_OUT_BITS'(c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en[LV+1]) begin
			out_valid_q <= vld_sk[LV];
		end
	end

	always_ff @(posedge clk) begin
		if (en[LV+1]) begin
			out_pat_q <= chosen;
		end
	end

	assign out_valid      = out_valid_q;
	assign output_pattern = out_pat_q;

endmodule

### design/ptgs_check.sv
// port-level checks for the sampler top level, attached by the bind at the end
// depends on ptgs_pkg and probabilistic_table_gate_sampler_unit
module ptgs_check #(
	parameter int MAX_OUT_BITS = ptgs_pkg::DEF_MAX_OUT_BITS
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_write,
	input logic [ptgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [ptgs_pkg::CFG_W-1:0]      cfg_data,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            mode,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [MAX_OUT_BITS-1:0]         output_pattern
);
	import ptgs_pkg::*;

	localparam int DEPTH = MAX_OUT_BITS + 2;
	localparam int CNT_W = $clog2(DEPTH + 2);

	logic [CFG_W-1:0]        ob_q;
	logic [CFG_W-1:0]        ob_eff;
	logic [MAX_OUT_BITS-1:0] col_mask;
	logic [CNT_W-1:0]        pend_q;
	logic                    smp_in;
	logic                    smp_out;

	assign smp_in  = in_valid && in_ready && mode == MODE_SAMPLE;
	assign smp_out = out_valid && out_ready;

	// shadow of the output width register and count of samples in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_q   <= '0;
			pend_q <= '0;
		end else begin
			if (cfg_write && cfg_index == REG_OUT_BITS) begin
				ob_q <= cfg_data;
			end
			if (smp_in && !smp_out) begin
				pend_q <= pend_q + 1'b1;
			end else if (smp_out && !smp_in) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	assign ob_eff   = (ob_q > CFG_W'(MAX_OUT_BITS)) ? CFG_W'(MAX_OUT_BITS) : ob_q;
	assign col_mask = ~({MAX_OUT_BITS{1'b1}} << ob_eff);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(output_pattern))
		else $error("stalled result changed or dropped");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result shown with no sample in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(DEPTH))
		else $error("more samples in flight than pipeline stages");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (output_pattern & ~col_mask) == '0)
		else $error("output pattern beyond the columns in use");

endmodule

bind probabilistic_table_gate_sampler_unit ptgs_check #(
	.MAX_OUT_BITS(MAX_OUT_BITS)
) u_ptgs_check (.*);

### verif/ptgs_draw_checker.sv
// port checker for the probabilistic table gate sampler: shadows the table and registers,
// predicts each drawn output pattern and compares it with the result transaction
// depends on ptgs_pkg
module ptgs_draw_checker #(
	parameter int IN_W   = ptgs_pkg::DEF_MAX_IN_BITS,
	parameter int OUT_W  = ptgs_pkg::DEF_MAX_OUT_BITS,
	parameter int PROB_W = ptgs_pkg::DEF_PROB_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ptgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptgs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           mode,
	input  logic [IN_W-1:0]                input_pattern,
	input  logic [OUT_W-1:0]               entry_column,
	input  logic [PROB_W-1:0]              entry_probability,
	input  logic [PROB_W-1:0]              random_fraction,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [OUT_W-1:0]               output_pattern,
	output int                             fail_count,
	output int                             pending
);

	logic [PROB_W-1:0] prob_shadow [0:(1 << (IN_W + OUT_W))-1];
	int                in_bits;
	int                out_bits;
	logic [OUT_W-1:0]  expected_patterns [$];
	logic [OUT_W-1:0]  want;

	// running sum over the selected row, first column whose sum passes the fraction, else the last one
	function automatic logic [OUT_W-1:0] inverse_cdf_pick(input logic [IN_W-1:0] pat,
			input logic [PROB_W-1:0] frac);
		logic [IN_W-1:0]       row;
		logic [PROB_W+OUT_W:0] acc;
		logic [OUT_W-1:0]      pick;
		bit                    hit;
		row  = pat & IN_W'((1 << in_bits) - 1);
		pick = OUT_W'((1 << out_bits) - 1);
		acc  = '0;
		hit  = 1'b0;
		for (int c = 0; c < (1 << out_bits); c++) begin
			acc += prob_shadow[{row, OUT_W'(c)}];
			if (!hit && acc > frac) begin
				pick = OUT_W'(c);
				hit  = 1'b1;
			end
		end
		return pick;
	endfunction

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bits  = 0;
			out_bits = 0;
			expected_patterns.delete();
			pending  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_patterns.size() == 0) begin
					$error("output_pattern: expected no transaction, actual %0d", output_pattern);
					fail_count++;
				end else begin
					want = expected_patterns.pop_front();
					if (output_pattern !== want) begin
						$error("output_pattern: expected %0d, actual %0d", want, output_pattern);
						fail_count++;
					end
				end
			end
			if (cfg_write) begin
				case (ptgs_pkg::cfg_reg_t'(cfg_index))
					ptgs_pkg::REG_IN_BITS: begin
						in_bits = (cfg_data > IN_W) ? IN_W : int'(cfg_data);
					end
					ptgs_pkg::REG_OUT_BITS: begin
						out_bits = (cfg_data > OUT_W) ? OUT_W : int'(cfg_data);
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (mode == ptgs_pkg::MODE_WRITE) begin
					prob_shadow[{input_pattern, entry_column}] = entry_probability;
				end else begin
					expected_patterns = {expected_patterns,
						inverse_cdf_pick(input_pattern, random_fraction)};
				end
			end
			pending = expected_patterns.size();
		end
	end

endmodule

### verif/tb.sv
// testbench top for probabilistic_table_gate_sampler_unit: clock, reset, table loads,
// draws and register phases with random idling on both channels; verdict from the checker
// depends on ptgs_pkg, probabilistic_table_gate_sampler_unit and ptgs_draw_checker
module tb;

	import ptgs_pkg::*;

	localparam int IN_W   = DEF_MAX_IN_BITS;
	localparam int OUT_W  = DEF_MAX_OUT_BITS;
	localparam int PROB_W = DEF_PROB_BITS;
	localparam int LAT    = OUT_W + 2;
	localparam int FULL   = 1 << PROB_W;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [IN_W-1:0]      input_pattern;
	logic [OUT_W-1:0]     entry_column;
	logic [PROB_W-1:0]    entry_probability;
	logic [PROB_W-1:0]    random_fraction;
	logic                 out_valid;
	logic                 out_ready;
	logic [OUT_W-1:0]     output_pattern;
	int                   fail_count;
	int                   pending;

	// stimulus-side view of the table and registers
	bit                   loaded [0:(1 << (IN_W + OUT_W))-1];
	int                   cur_ib;
	int                   cur_ob;
	int                   row_sum [0:(1 << OUT_W)-1];
	int                   sent;
	bit                   calm;

	probabilistic_table_gate_sampler_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.input_pattern     (input_pattern),
		.entry_column      (entry_column),
		.entry_probability (entry_probability),
		.random_fraction   (random_fraction),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.output_pattern    (output_pattern)
	);

	ptgs_draw_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.input_pattern     (input_pattern),
		.entry_column      (entry_column),
		.entry_probability (entry_probability),
		.random_fraction   (random_fraction),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.output_pattern    (output_pattern),
		.fail_count        (fail_count),
		.pending           (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5000000;
		$display("probabilistic_table_gate_sampler_unit verification failed");
		$finish;
	end

	// result side back-pressure in bursts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready = 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	function automatic logic [IN_W-1:0] row_mask();
		return IN_W'((1 << cur_ib) - 1);
	endfunction

	function automatic int pick_bits();
		if ($urandom_range(0, 9) < 3)
			return $urandom_range(0, 1) ? 7 : 0;
		return $urandom_range(0, 4);
	endfunction

	// one input transaction, called at a falling edge, returns at a falling edge
	task automatic push_item(input mode_t m, input logic [IN_W-1:0] pat,
			input logic [OUT_W-1:0] col, input logic [PROB_W-1:0] prob,
			input logic [PROB_W-1:0] frac);
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		mode              = m;
		input_pattern     = pat;
		entry_column      = col;
		entry_probability = prob;
		random_fraction   = frac;
		in_valid          = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_WRITE)
			loaded[{pat, col}] = 1'b1;
		sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic put_entry(input logic [IN_W-1:0] pat, input logic [OUT_W-1:0] col,
			input logic [PROB_W-1:0] prob);
		push_item(MODE_WRITE, pat, col, prob, PROB_W'($urandom));
	endtask

	// never let a draw touch an entry that was not loaded
	task automatic draw(input logic [IN_W-1:0] pat, input logic [PROB_W-1:0] frac);
		logic [IN_W-1:0] row;
		row = pat & row_mask();
		for (int c = 0; c < (1 << cur_ob); c++) begin
			if (!loaded[{row, OUT_W'(c)}])
				put_entry(row, OUT_W'(c), PROB_W'($urandom_range(0, (FULL - 1) >> cur_ob)));
		end
		push_item(MODE_SAMPLE, pat, OUT_W'($urandom), PROB_W'($urandom), frac);
	endtask

	task automatic set_reg(input cfg_reg_t idx, input int value);
		cfg_index = idx;
		cfg_data  = CFG_W'(value);
		cfg_write = 1'b1;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == REG_IN_BITS)
			cur_ib = (value > IN_W) ? IN_W : value;
		else
			cur_ob = (value > OUT_W) ? OUT_W : value;
	endtask

	// registers change only with the pipeline drained
	task automatic configure(input int ib, input int ob);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LAT + 4) @(negedge clk);
		set_reg(REG_IN_BITS, ib);
		set_reg(REG_OUT_BITS, ob);
	endtask

	// normalized row: entries add up to one unless the last column is capped at FULL - 1; remainder in the last column
	task automatic load_row(input logic [IN_W-1:0] row);
		int w [0:(1 << OUT_W)-1];
		int total;
		int acc;
		int val;
		int ncols;
		ncols = 1 << cur_ob;
		total = 0;
		for (int c = 0; c < ncols; c++) begin
			w[c] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
			total += w[c];
		end
		if (total == 0) begin
			w[0]  = 1;
			total = 1;
		end
		acc = 0;
		for (int c = 0; c < ncols; c++) begin
			val = (c == ncols - 1) ? FULL - acc : (w[c] * FULL) / total;
			if (val > FULL - 1)
				val = FULL - 1;
			acc += val;
			row_sum[c] = acc;
			put_entry(row, OUT_W'(c), PROB_W'(val));
		end
	endtask

	// draws aimed mostly at the cumulative boundaries of the row just loaded, plus the extremes and random fractions
	task automatic sample_row(input logic [IN_W-1:0] row);
		int c;
		int frac;
		repeat ($urandom_range(3, 8)) begin
			c = $urandom_range(0, (1 << cur_ob) - 1);
			case ($urandom_range(0, 4))
				0: frac = 0;
				1: frac = FULL - 1;
				2: frac = (row_sum[c] > FULL - 1) ? FULL - 1 : row_sum[c];
				3: frac = (row_sum[c] == 0) ? 0 : row_sum[c] - 1;
				default: frac = $urandom_range(0, FULL - 1);
			endcase
			// bits above the used inputs must not matter
			draw(row | (IN_W'($urandom) & ~row_mask()), PROB_W'(frac));
		end
	endtask

	initial begin
		int target;
		int sel;
		logic [IN_W-1:0] row;
		arst_n            = 1'b0;
		cfg_write         = 1'b0;
		cfg_index         = REG_IN_BITS;
		cfg_data          = '0;
		in_valid          = 1'b0;
		mode              = MODE_WRITE;
		input_pattern     = '0;
		entry_column      = '0;
		entry_probability = '0;
		random_fraction   = '0;
		cur_ib            = 0;
		cur_ob            = 0;
		sent              = 0;
		calm              = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset registers: one row, one column
		put_entry('1, '1, '1);
		put_entry('0, '0, '0);
		draw('1, '0);
		draw('0, '1);

		// oversized input register saturates, two columns, strict compare at the boundary
		configure(7, 1);
		put_entry('1, OUT_W'(0), PROB_W'(30000));
		put_entry('1, OUT_W'(1), PROB_W'(35536));
		draw('1, PROB_W'(29999));
		draw('1, PROB_W'(30000));
		draw('1, '1);
		// draw right behind the write it depends on
		put_entry('1, OUT_W'(0), '1);
		draw('1, PROB_W'(FULL - 2));

		// widest row that never reaches the fraction falls to the last column
		configure(0, 7);
		for (int c = 0; c < (1 << OUT_W); c++)
			put_entry('0, OUT_W'(c), PROB_W'(100));
		draw(IN_W'(10), '1);
		draw('0, '0);

		target = sent + 750;
		while (sent < target) begin
			configure(pick_bits(), pick_bits());
			repeat ($urandom_range(3, 8)) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) begin
					row = IN_W'($urandom) & row_mask();
					load_row(row);
					sample_row(row);
				end else if (sel < 8) begin
					put_entry(IN_W'($urandom), OUT_W'($urandom), PROB_W'($urandom));
				end else begin
					draw(IN_W'($urandom), PROB_W'($urandom));
				end
				calm = (sent >= target - 150);
			end
		end

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LAT + 10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("probabilistic_table_gate_sampler_unit verification clean");
		else
			$display("probabilistic_table_gate_sampler_unit verification failed");
		$finish;
	end

endmodule

### sim.f
design/ptgs_pkg.sv
design/probabilistic_table_gate_sampler_unit.sv
design/ptgs_check.sv
verif/ptgs_draw_checker.sv
verif/tb.sv
